/* hdl/nbody_pkg.sv */
package nbody_pkg;

   localparam int DefaultMaxBodies = 64;
   localparam logic [31:0] SofteningReset = 32'd1677;
   localparam int CoordWidth = 32;
   localparam int SumWidth = 48;
   localparam int ReqDataWidth = 224;
   localparam int RspDataWidth = 296;
   localparam logic [63:0] Sat62 = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] AccMax = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] AccMin = -64'sh0000_8000_0000_0000;
   localparam logic [1:0] JerkCoef = 2'd3;

   typedef logic signed [63:0] sval_type;

   // Saturates a value to the signed 48-bit range of a sum.
   function automatic sval_type sat_acc(input sval_type a);
      sval_type r;
      r = a;
      if (a > AccMax) begin
         r = AccMax;
      end else if (a < AccMin) begin
         r = AccMin;
      end
      return r;
   endfunction

   // Saturates to a magnitude of 2^62-1.
   function automatic sval_type sat62(input sval_type a);
      sval_type r;
      r = a;
      if (a > $signed(Sat62)) begin
         r = $signed(Sat62);
      end else if (a < -$signed(Sat62)) begin
         r = -$signed(Sat62);
      end
      return r;
   endfunction

endpackage

/* hdl/nbody_ram.sv */
module nbody_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

/* hdl/nbody_mulshr.sv */
module nbody_mulshr (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   input  logic [5:0]  shift,
   output logic        done,
   output logic [63:0] result
);
   import nbody_pkg::*;

   logic [63:0]  a_ff, b_ff;
   logic [5:0]   sh_ff;
   logic [127:0] acc_ff;
   logic [2:0]   step_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [63:0]  pp;
   logic [127:0] pp_wide;
   logic [127:0] shifted;

   assign done = done_ff;

   always_comb begin
      unique case (step_ff[1:0])
         2'd0: pp = a_ff[31:0] * b_ff[31:0];
         2'd1: pp = a_ff[31:0] * b_ff[63:32];
         2'd2: pp = a_ff[63:32] * b_ff[31:0];
         default: pp = a_ff[63:32] * b_ff[63:32];
      endcase
      unique case (step_ff[1:0])
         2'd0: pp_wide = {64'd0, pp};
         2'd1, 2'd2: pp_wide = {32'd0, pp, 32'd0};
         default: pp_wide = {pp, 64'd0};
      endcase
      shifted = acc_ff >> sh_ff;
      if (shifted[127:62] != '0) begin
         result = Sat62;
      end else begin
         result = shifted[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            a_ff <= a;
            b_ff <= b;
            sh_ff <= shift;
            acc_ff <= '0;
         end else if (busy_ff) begin
            acc_ff <= acc_ff + pp_wide;
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

/* hdl/nbody_accel_jerk_direct_sum_unit.sv */
// Loads one body per req transfer (position, velocity, mass), one cycle each; the
// transfer that carries tlast starts the pair sweep. Every unordered pair is evaluated
// once by one sequencer around a shared 64x64 multiplier (four 32x32 partial products
// per product), a 32-step bit-serial square root and a 64-step restoring divider, and
// applied to both bodies by read-modify-write of the sum memories. A pair of coincident
// bodies with zero softening skips the root, divide and write-back. The pair sweep
// follows a clearing sweep over the N sum entries, then N rsp transfers go out in load
// order, each read through S_OUT_RD and S_OUT_WAIT, then held in S_OUT while rsp_tready
// stays low. Bodies beyond MaxBodies are dropped; their tlast still starts the sweep.
module nbody_accel_jerk_direct_sum_unit #(
   parameter int MaxBodies = nbody_pkg::DefaultMaxBodies
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic req_tvalid,
   output logic req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, body_mass
   input  logic [nbody_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // body_index, acc_x, acc_y, acc_z, jerk_x, jerk_y, jerk_z, zero pad
   output logic [nbody_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic rsp_tlast
);
   import nbody_pkg::*;

   localparam int AW = $clog2(MaxBodies);
   localparam int CW = $clog2(MaxBodies + 1);
   localparam int BodyW = 7 * CoordWidth;
   localparam int SumsW = 6 * SumWidth;

   typedef enum logic [4:0] {
      S_LOAD, S_CLEAR, S_RD_I, S_RD_J, S_DIFF, S_SQ, S_SQ_W, S_SQRT, S_DIV,
      S_M_INV2, S_M_Q, S_M_VR, S_M_QD, S_M_TI, S_M_TJ, S_AXIS, S_M_WD,
      S_M_AI, S_M_AJ, S_M_JI, S_M_JJ, S_WB_RD, S_WB_WAIT, S_WB_WR, S_NEXT,
      S_OUT_RD, S_OUT_WAIT, S_OUT
   } state_type;

   state_type state_ff;
   logic [31:0] soft_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] i_ff, j_ff, ptr_ff;
   logic [1:0] k_ff;
   logic side_ff;

   logic body_we;
   logic [AW-1:0] body_waddr, body_raddr;
   logic [BodyW-1:0] body_rdata;
   logic sum_we;
   logic [AW-1:0] sum_waddr, sum_raddr;
   logic [SumsW-1:0] sum_wdata, sum_rdata;

   nbody_ram #(.Width(BodyW), .Depth(MaxBodies)) u_body (
      .clock(clock), .wr_en(body_we), .wr_addr(body_waddr),
      .wr_data(req_tdata), .rd_addr(body_raddr), .rd_data(body_rdata));

   nbody_ram #(.Width(SumsW), .Depth(MaxBodies)) u_sums (
      .clock(clock), .wr_en(sum_we), .wr_addr(sum_waddr),
      .wr_data(sum_wdata), .rd_addr(sum_raddr), .rd_data(sum_rdata));

   logic [BodyW-1:0] bi_ff;
   sval_type d_ff [3];
   sval_type v_ff [3];
   sval_type s_ff, vr_ff, inv1_ff, inv2_ff, q_ff, qd_ff, ti_ff, tj_ff, w_ff;
   sval_type ai_ff [3], aj_ff [3], ji_ff [3], jj_ff [3];
   logic [63:0] x_ff, res_ff, bit_ff, quo_ff, rem_ff, t_ff;
   logic [6:0] it_ff;
   logic neg_ff;

   logic mul_start_ff, mul_done;
   logic [63:0] mul_a, mul_b, mul_r;
   logic [5:0] mul_sh;
   logic [63:0] mul_a_ff, mul_b_ff;
   logic [5:0] mul_sh_ff;

   nbody_mulshr u_mul (
      .clock(clock), .reset(reset), .start(mul_start_ff), .a(mul_a), .b(mul_b),
      .shift(mul_sh), .done(mul_done), .result(mul_r));

   assign mul_a = mul_a_ff;
   assign mul_b = mul_b_ff;
   assign mul_sh = mul_sh_ff;

   function automatic logic [63:0] mag(input sval_type a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   function automatic sval_type sx32(input logic [31:0] a);
      return sval_type'($signed(a));
   endfunction

   function automatic sval_type sx48(input logic [SumWidth-1:0] a);
      return sval_type'($signed(a));
   endfunction

   function automatic sval_type sgn(input logic n, input logic [63:0] m);
      return n ? -$signed(m) : $signed(m);
   endfunction

   logic mul_pend_ff;
   logic [63:0] trial;
   logic [64:0] rem_sh;

   always_comb begin
      body_we = (state_ff == S_LOAD) && req_tvalid && req_tready
         && (count_ff < CW'(MaxBodies));
      body_waddr = count_ff[AW-1:0];
      body_raddr = (state_ff == S_RD_I) ? i_ff : j_ff;
      sum_raddr = (state_ff == S_OUT_RD || state_ff == S_OUT_WAIT || state_ff == S_OUT)
         ? ptr_ff : (side_ff ? j_ff : i_ff);
      sum_waddr = (state_ff == S_CLEAR) ? ptr_ff : (side_ff ? j_ff : i_ff);
      sum_we = (state_ff == S_CLEAR) || (state_ff == S_WB_WR);
      sum_wdata = '0;
      if (state_ff == S_WB_WR) begin
         for (int a = 0; a < 3; a++) begin
            sum_wdata[a*SumWidth +: SumWidth] = SumWidth'(sat_acc(
               sx48(sum_rdata[a*SumWidth +: SumWidth]) + (side_ff ? aj_ff[a] : ai_ff[a])));
            sum_wdata[(a+3)*SumWidth +: SumWidth] = SumWidth'(sat_acc(
               sx48(sum_rdata[(a+3)*SumWidth +: SumWidth]) + (side_ff ? jj_ff[a] : ji_ff[a])));
         end
      end
      trial = res_ff + bit_ff;
      rem_sh = {rem_ff, quo_ff[63]};
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {{(RspDataWidth-6-SumsW){1'b0}}, sum_rdata, 6'(ptr_ff)};
   assign rsp_tlast = (CW'(ptr_ff) + CW'(1) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         soft_ff <= SofteningReset;
         count_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         ptr_ff <= '0;
         k_ff <= '0;
         side_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         mul_pend_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         if (csr_wr_en) begin
            soft_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (req_tvalid) begin
                  if (count_ff < CW'(MaxBodies)) begin
                     count_ff <= count_ff + CW'(1);
                  end
                  if (req_tlast) begin
                     ptr_ff <= '0;
                     state_ff <= S_CLEAR;
                  end
               end
            end
            S_CLEAR: begin
               ptr_ff <= ptr_ff + AW'(1);
               if (CW'(ptr_ff) + CW'(1) >= count_ff) begin
                  ptr_ff <= '0;
                  i_ff <= AW'(1);
                  j_ff <= '0;
                  state_ff <= (count_ff > CW'(1)) ? S_RD_I : S_OUT_RD;
               end
            end
            S_RD_I: state_ff <= S_RD_J;
            S_RD_J: begin
               bi_ff <= body_rdata;
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               for (int a = 0; a < 3; a++) begin
                  d_ff[a] <= sx32(body_rdata[a*32 +: 32]) - sx32(bi_ff[a*32 +: 32]);
                  v_ff[a] <= sx32(body_rdata[(a+3)*32 +: 32]) - sx32(bi_ff[(a+3)*32 +: 32]);
               end
               bi_ff[BodyW-1 -: 32] <= bi_ff[BodyW-1 -: 32];
               t_ff <= {32'd0, body_rdata[BodyW-1 -: 32]};
               s_ff <= sval_type'({32'd0, soft_ff});
               vr_ff <= '0;
               k_ff <= '0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               mul_a_ff <= mag(d_ff[k_ff]);
               mul_b_ff <= mag(d_ff[k_ff]);
               mul_sh_ff <= 6'd24;
               mul_start_ff <= 1'b1;
               mul_pend_ff <= 1'b0;
               state_ff <= S_SQ_W;
            end
            S_SQ_W: begin
               if (mul_done) begin
                  if (!mul_pend_ff) begin
                     s_ff <= s_ff + sval_type'(mul_r);
                     mul_a_ff <= mag(d_ff[k_ff]);
                     mul_b_ff <= mag(v_ff[k_ff]);
                     neg_ff <= d_ff[k_ff][63] ^ v_ff[k_ff][63];
                     mul_start_ff <= 1'b1;
                     mul_pend_ff <= 1'b1;
                  end else begin
                     vr_ff <= vr_ff + sgn(neg_ff, mul_r);
                     if (k_ff == 2'd2) begin
                        x_ff <= 64'(s_ff) << 22;
                        res_ff <= '0;
                        bit_ff <= 64'd1 << 62;
                        it_ff <= '0;
                        state_ff <= (s_ff == '0) ? S_NEXT : S_SQRT;
                     end else begin
                        k_ff <= k_ff + 2'd1;
                        state_ff <= S_SQ;
                     end
                  end
               end
            end
            S_SQRT: begin
               if (x_ff >= trial) begin
                  x_ff <= x_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               it_ff <= it_ff + 7'd1;
               if (it_ff == 7'd31) begin
                  it_ff <= '0;
                  quo_ff <= 64'd1 << 55;
                  rem_ff <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (it_ff == 7'd0) begin
                  t_ff[63:32] <= t_ff[31:0];
               end
               if (rem_sh >= {1'b0, res_ff}) begin
                  rem_ff <= 64'(rem_sh - {1'b0, res_ff});
                  quo_ff <= {quo_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[63:0];
                  quo_ff <= {quo_ff[62:0], 1'b0};
               end
               it_ff <= it_ff + 7'd1;
               if (it_ff == 7'd63) begin
                  state_ff <= S_M_INV2;
               end
            end
            S_M_INV2: begin
               inv1_ff <= sval_type'(quo_ff);
               mul_a_ff <= quo_ff;
               mul_b_ff <= quo_ff;
               mul_sh_ff <= 6'd32;
               mul_start_ff <= 1'b1;
               state_ff <= S_M_Q;
            end
            S_M_Q: begin
               if (mul_done) begin
                  inv2_ff <= sval_type'(mul_r);
                  mul_a_ff <= 64'(inv1_ff);
                  mul_b_ff <= mul_r;
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M_VR;
               end
            end
            S_M_VR: begin
               if (mul_done) begin
                  q_ff <= sval_type'(mul_r);
                  mul_a_ff <= mag(vr_ff);
                  mul_b_ff <= 64'(inv2_ff);
                  mul_sh_ff <= 6'd24;
                  neg_ff <= vr_ff[63];
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M_QD;
               end
            end
            S_M_QD: begin
               if (mul_done) begin
                  mul_a_ff <= mul_r;
                  mul_b_ff <= 64'(JerkCoef);
                  mul_sh_ff <= 6'd0;
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M_TI;
               end
            end
            S_M_TI: begin
               if (mul_done) begin
                  qd_ff <= sgn(!neg_ff, mul_r);
                  mul_a_ff <= 64'(q_ff);
                  mul_b_ff <= {32'd0, bi_ff[BodyW-1 -: 32]};
                  mul_sh_ff <= 6'd32;
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M_TJ;
               end
            end
            S_M_TJ: begin
               if (mul_done) begin
                  ti_ff <= sval_type'(mul_r);
                  mul_a_ff <= 64'(q_ff);
                  mul_b_ff <= {32'd0, t_ff[63:32]};
                  mul_start_ff <= 1'b1;
                  k_ff <= '0;
                  state_ff <= S_AXIS;
               end
            end
            S_AXIS: begin
               if (mul_done) begin
                  tj_ff <= sval_type'(mul_r);
                  mul_a_ff <= mag(qd_ff);
                  mul_b_ff <= mag(d_ff[k_ff]);
                  mul_sh_ff <= 6'd24;
                  neg_ff <= qd_ff[63] ^ d_ff[k_ff][63];
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M_WD;
               end
            end
            S_M_WD: begin
               if (mul_done) begin
                  w_ff <= sat62((v_ff[k_ff] <<< 8) + sgn(neg_ff, mul_r));
                  mul_a_ff <= mag(d_ff[k_ff]);
                  mul_b_ff <= 64'(tj_ff);
                  neg_ff <= d_ff[k_ff][63];
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M_AI;
               end
            end
            S_M_AI: begin
               if (mul_done) begin
                  ai_ff[k_ff] <= sgn(neg_ff, mul_r);
                  mul_b_ff <= 64'(ti_ff);
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M_AJ;
               end
            end
            S_M_AJ: begin
               if (mul_done) begin
                  aj_ff[k_ff] <= sgn(!neg_ff, mul_r);
                  mul_a_ff <= mag(w_ff);
                  mul_b_ff <= 64'(tj_ff);
                  mul_sh_ff <= 6'd32;
                  neg_ff <= w_ff[63];
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M_JI;
               end
            end
            S_M_JI: begin
               if (mul_done) begin
                  ji_ff[k_ff] <= sgn(neg_ff, mul_r);
                  mul_b_ff <= 64'(ti_ff);
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M_JJ;
               end
            end
            S_M_JJ: begin
               if (mul_done) begin
                  jj_ff[k_ff] <= sgn(!neg_ff, mul_r);
                  if (k_ff == 2'd2) begin
                     side_ff <= 1'b0;
                     state_ff <= S_WB_RD;
                  end else begin
                     k_ff <= k_ff + 2'd1;
                     mul_a_ff <= 64'(tj_ff);
                     mul_b_ff <= 64'd1;
                     mul_sh_ff <= 6'd0;
                     mul_start_ff <= 1'b1;
                     state_ff <= S_AXIS;
                  end
               end
            end
            S_WB_RD: state_ff <= S_WB_WAIT;
            S_WB_WAIT: state_ff <= S_WB_WR;
            S_WB_WR: begin
               if (!side_ff) begin
                  side_ff <= 1'b1;
                  state_ff <= S_WB_RD;
               end else begin
                  side_ff <= 1'b0;
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if (j_ff + AW'(1) < i_ff) begin
                  j_ff <= j_ff + AW'(1);
                  state_ff <= S_RD_I;
               end else if (CW'(i_ff) + CW'(1) < count_ff) begin
                  i_ff <= i_ff + AW'(1);
                  j_ff <= '0;
                  state_ff <= S_RD_I;
               end else begin
                  ptr_ff <= '0;
                  state_ff <= S_OUT_RD;
               end
            end
            S_OUT_RD: state_ff <= S_OUT_WAIT;
            S_OUT_WAIT: state_ff <= S_OUT;
            S_OUT: begin
               if (rsp_tready) begin
                  if (rsp_tlast) begin
                     count_ff <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     ptr_ff <= ptr_ff + AW'(1);
                     state_ff <= S_OUT_RD;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("Result offered while loading bodies.");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MaxBodies))
      else $error("Body count beyond capacity.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT) |-> (j_ff < i_ff))
      else $error("Pair order broken.");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (count_ff == '0))
      else $error("Body count not cleared after the final result.");

endmodule
